// ----- hw/rtl/rce_pkg.sv -----
// shared types and constants for the reference-counted entry cache
// no dependencies
`default_nettype none
package rce_pkg;
  localparam int CAPACITY_DEF = 32;
  localparam int REF_BITS_DEF = 16;
  localparam int KEY_W        = 48;
  localparam int ADDR_W       = 32;
  localparam int PORT_W       = 16;
  localparam int MAX_W        = 6;
  localparam int STATUS_W     = 3;
  localparam logic [MAX_W-1:0] MAX_RESET = 6'd16;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HELD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic match;
    logic update;
    logic evict;
    logic hit_write;
    logic unlink;
    logic append;
    logic insert;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rce_cell.sv -----
// one table entry: key, count, validity and its place in the free queue
// depends on rce_pkg
`default_nettype none
module rce_cell #(
  parameter int REF_BITS = rce_pkg::REF_BITS_DEF,
  parameter int RANK_W   = 6
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  rce_pkg::cell_cmd_t         cmd,
  input  wire [rce_pkg::KEY_W-1:0]   key_i,
  input  wire [REF_BITS-1:0]         refs_new_i,
  input  wire [RANK_W-1:0]           rank_arg_i,
  input  wire [RANK_W-1:0]           append_rank_i,
  input  wire                        seen_in,
  output logic                       seen_out,
  output logic                       hit_o,
  output logic                       first_o,
  output logic [REF_BITS-1:0]        refs_o,
  output logic [RANK_W-1:0]          rank_o
);
  logic                      valid_r, free_r, hit_r, first_r;
  logic [rce_pkg::KEY_W-1:0] key_r;
  logic [REF_BITS-1:0]       refs_r;
  logic [RANK_W-1:0]         rank_r;

  // empty-slot priority token runs down the row
  assign seen_out = seen_in | ~valid_r;
  assign hit_o    = hit_r;
  assign first_o  = first_r;
  assign refs_o   = refs_r & {REF_BITS{hit_r}};
  assign rank_o   = rank_r & {RANK_W{hit_r}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (cmd.update) begin
      if (hit_r && cmd.hit_write) begin
        if (cmd.unlink) free_r <= 1'b0;
        if (cmd.append) free_r <= 1'b1;
      end
      if (first_r && cmd.insert) begin
        valid_r <= 1'b1;
        free_r  <= 1'b0;
      end
    end else if (cmd.evict) begin
      if (free_r && rank_r < rank_arg_i) begin
        valid_r <= 1'b0;
        free_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_r   <= valid_r && (key_r == key_i);
      first_r <= ~valid_r & ~seen_in;
    end
    if (cmd.update) begin
      if (hit_r && cmd.hit_write) begin
        refs_r <= refs_new_i;
        if (cmd.append) rank_r <= append_rank_i;
      end else if (cmd.unlink && free_r && rank_r > rank_arg_i) begin
        // close the gap left in the queue
        rank_r <= rank_r - 1'b1;
      end
      if (first_r && cmd.insert) begin
        key_r  <= key_i;
        refs_r <= {{(REF_BITS-1){1'b0}}, 1'b1};
      end
    end else if (cmd.evict) begin
      if (free_r && rank_r >= rank_arg_i) rank_r <= rank_r - rank_arg_i;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/refcounted_entry_cache.sv -----
// top level: sequencer driving a row of entry cells
// depends on rce_pkg and rce_cell
// flow: a start transfer is taken only in idle, then the request passes the match, update
// and evict states across the cell row, then the result register, which raises the result strobe
// busy is high from each start until the sequencer is back in idle; results cannot be stalled
// reset empties the table and sets max_entries to 16
`default_nettype none
module refcounted_entry_cache #(
  parameter int CAPACITY = rce_pkg::CAPACITY_DEF,
  parameter int REF_BITS = rce_pkg::REF_BITS_DEF,
  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_action,
  input  wire [rce_pkg::ADDR_W-1:0]    in_address,
  input  wire [rce_pkg::PORT_W-1:0]    in_port,
  input  wire                          cfg_we,
  input  wire [rce_pkg::MAX_W-1:0]     cfg_wdata,
  output logic                         out_strobe,
  output logic [rce_pkg::STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [REF_BITS-1:0]          out_ref_count,
  output logic [CNT_W-1:0]             out_evicted,
  output logic [CNT_W-1:0]             out_occupancy
);
  localparam int CW = (CNT_W > rce_pkg::MAX_W) ? CNT_W : rce_pkg::MAX_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_UPDATE = 4'b0100,
    S_EVICT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [rce_pkg::MAX_W-1:0] max_r;
  logic                      action_r;
  logic [rce_pkg::KEY_W-1:0] key_r;
  logic [CNT_W-1:0]          count_r, count_nxt, freecnt_r, freecnt_nxt;
  logic [rce_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [REF_BITS-1:0]       refs_r, refs_nxt;

  rce_pkg::cell_cmd_t     cmd;
  logic [CAPACITY:0]      seen;
  logic [CAPACITY-1:0]    hit_v, first_v;
  logic [REF_BITS-1:0]    cell_refs [CAPACITY];
  logic [CNT_W-1:0]       cell_rank [CAPACITY];
  logic [REF_BITS-1:0]    refs_old, refs_new;
  logic [CNT_W-1:0]       rank_hit, rank_arg, evict_k;
  logic [SLOT_W-1:0]      hit_slot, first_slot;
  logic                   found, has_empty;
  logic [CW-1:0]          cnt_x, max_x, over;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rce_cell #(.REF_BITS(REF_BITS), .RANK_W(CNT_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd), .key_i(key_r),
      .refs_new_i(refs_new), .rank_arg_i(rank_arg), .append_rank_i(freecnt_r),
      .seen_in(seen[i]), .seen_out(seen[i+1]), .hit_o(hit_v[i]), .first_o(first_v[i]),
      .refs_o(cell_refs[i]), .rank_o(cell_rank[i])
    );
  end

  // hits are one-hot, first_v is one-hot or empty: plain or-reduction
  always_comb begin
    refs_old   = '0;
    rank_hit   = '0;
    hit_slot   = '0;
    first_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      refs_old = refs_old | cell_refs[i];
      rank_hit = rank_hit | cell_rank[i];
      if (hit_v[i])   hit_slot   = hit_slot   | SLOT_W'(i);
      if (first_v[i]) first_slot = first_slot | SLOT_W'(i);
    end
  end

  assign found     = |hit_v;
  assign has_empty = |first_v;
  assign cnt_x     = CW'(count_r);
  assign max_x     = CW'(max_r);
  assign over      = cnt_x - max_x;

  always_comb begin
    evict_k = '0;
    if (cnt_x > max_x) begin
      evict_k = (over > CW'(freecnt_r)) ? freecnt_r : CNT_W'(over);
    end
  end

  always_comb begin
    cmd         = '0;
    refs_new    = refs_old;
    rank_arg    = rank_hit;
    count_nxt   = count_r;
    freecnt_nxt = freecnt_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    refs_nxt    = refs_r;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_EVICT;
        slot_nxt   = '0;
        refs_nxt   = '0;
        if (!action_r) begin
          if (found) begin
            cmd.hit_write = 1'b1;
            if (refs_old == '0) begin
              cmd.unlink  = 1'b1;
              freecnt_nxt = freecnt_r - 1'b1;
            end
            // count saturates
            if (refs_old != {REF_BITS{1'b1}}) refs_new = refs_old + 1'b1;
            status_nxt = rce_pkg::ST_HIT;
            slot_nxt   = hit_slot;
            refs_nxt   = refs_new;
          end else if (has_empty) begin
            cmd.insert = 1'b1;
            count_nxt  = count_r + 1'b1;
            status_nxt = rce_pkg::ST_INSERTED;
            slot_nxt   = first_slot;
            refs_nxt   = {{(REF_BITS-1){1'b0}}, 1'b1};
          end else begin
            status_nxt = rce_pkg::ST_FULL;
          end
        end else begin
          if (!found) begin
            status_nxt = rce_pkg::ST_UNKNOWN;
          end else if (refs_old == '0) begin
            status_nxt = rce_pkg::ST_UNKNOWN;
            slot_nxt   = hit_slot;
          end else begin
            cmd.hit_write = 1'b1;
            refs_new      = refs_old - 1'b1;
            slot_nxt      = hit_slot;
            refs_nxt      = refs_new;
            if (refs_new == '0) begin
              cmd.append  = 1'b1;
              freecnt_nxt = freecnt_r + 1'b1;
              status_nxt  = rce_pkg::ST_FREED;
            end else begin
              status_nxt = rce_pkg::ST_HELD;
            end
          end
        end
      end
      S_EVICT: begin
        cmd.evict   = 1'b1;
        rank_arg    = evict_k;
        count_nxt   = count_r - evict_k;
        freecnt_nxt = freecnt_r - evict_k;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      max_r      <= rce_pkg::MAX_RESET;
      count_r    <= '0;
      freecnt_r  <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      freecnt_r  <= freecnt_nxt;
      out_strobe <= (state_r == S_EVICT);
      if (cfg_we) max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      action_r <= in_action;
      key_r    <= {in_address, in_port};
    end
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    refs_r   <= refs_nxt;
    if (state_r == S_EVICT) begin
      out_status    <= status_r;
      out_slot      <= slot_r;
      out_ref_count <= refs_r;
      out_evicted   <= evict_k;
      out_occupancy <= count_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- tb/refcounted_entry_cache_tb.sv -----
// self-checking testbench for refcounted_entry_cache: directed table and random phases
// depends on rce_pkg and the refcounted_entry_cache rtl
`default_nettype none
module refcounted_entry_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP     = 32;
  localparam int REF_TOP = 65535;
  localparam int NONE    = CAP;
  localparam int WD_LIMIT = 5000;
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_REL = 1'b1;

  typedef struct {
    logic [rce_pkg::STATUS_W-1:0] status;
    logic [4:0]          slot;
    logic [15:0]         refs;
    logic [5:0]          evicted;
    logic [5:0]          occupancy;
  } lookup_res_t;

  typedef struct {
    logic                         act;
    logic [rce_pkg::ADDR_W-1:0]   addr;
    logic [rce_pkg::PORT_W-1:0]   port;
    bit                           typed;
    logic [rce_pkg::STATUS_W-1:0] status;
    logic [4:0]          slot;
    logic [15:0]         refs;
    logic [5:0]          occ;
  } table_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_action = 0;
  logic [rce_pkg::ADDR_W-1:0] in_address = '0;
  logic [rce_pkg::PORT_W-1:0] in_port = '0;
  logic cfg_we = 0;
  logic [rce_pkg::MAX_W-1:0] cfg_wdata = '0;
  logic out_strobe;
  logic [rce_pkg::STATUS_W-1:0] out_status;
  logic [4:0] out_slot;
  logic [15:0] out_ref_count;
  logic [5:0] out_evicted;
  logic [5:0] out_occupancy;

  refcounted_entry_cache i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_address(in_address), .in_port(in_port),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_slot(out_slot),
    .out_ref_count(out_ref_count), .out_evicted(out_evicted),
    .out_occupancy(out_occupancy)
  );

  always #6 clk = ~clk;

  // cache model state
  bit                        ent_valid [CAP];
  logic [rce_pkg::KEY_W-1:0] ent_key [CAP];
  int               ent_refs [CAP];
  int               nxt [CAP];
  int               prv [CAP];
  int               fl_head = NONE;
  int               fl_tail = NONE;
  int               occ_cnt = 0;
  int               max_ent = int'(rce_pkg::MAX_RESET);

  lookup_res_t      pending_results[$];
  int               errors = 0;
  int               idle_cycles = 0;
  logic [rce_pkg::KEY_W-1:0] key_pool [48];

  function automatic void free_unlink(int s);
    int p, n;
    p = prv[s];
    n = nxt[s];
    if (p < CAP) nxt[p] = n; else fl_head = n;
    if (n < CAP) prv[n] = p; else fl_tail = p;
    nxt[s] = NONE;
    prv[s] = NONE;
  endfunction

  function automatic void free_append(int s);
    prv[s] = fl_tail;
    nxt[s] = NONE;
    if (fl_tail < CAP) nxt[fl_tail] = s; else fl_head = s;
    fl_tail = s;
  endfunction

  function automatic lookup_res_t cache_step(logic act, logic [rce_pkg::KEY_W-1:0] key);
    lookup_res_t res;
    int s, i, ev;
    s = NONE;
    ev = 0;
    res.slot = '0;
    res.refs = '0;
    for (i = CAP - 1; i >= 0; i--)
      if (ent_valid[i] && ent_key[i] == key) s = i;
    if (act == ACT_GET) begin
      if (s < CAP) begin
        if (ent_refs[s] == 0) free_unlink(s);
        if (ent_refs[s] < REF_TOP) ent_refs[s]++;
        res.status = rce_pkg::ST_HIT;
        res.slot = s[4:0];
        res.refs = ent_refs[s][15:0];
      end else begin
        for (i = 0; i < CAP && ent_valid[i]; i++) ;
        if (i < CAP) begin
          ent_valid[i] = 1;
          ent_key[i] = key;
          ent_refs[i] = 1;
          nxt[i] = NONE;
          prv[i] = NONE;
          occ_cnt++;
          res.status = rce_pkg::ST_INSERTED;
          res.slot = i[4:0];
          res.refs = 16'd1;
        end else begin
          res.status = rce_pkg::ST_FULL;
        end
      end
    end else if (s >= CAP) begin
      res.status = rce_pkg::ST_UNKNOWN;
    end else if (ent_refs[s] == 0) begin
      res.status = rce_pkg::ST_UNKNOWN;
      res.slot = s[4:0];
    end else begin
      ent_refs[s]--;
      res.slot = s[4:0];
      res.refs = ent_refs[s][15:0];
      if (ent_refs[s] == 0) begin
        free_append(s);
        res.status = rce_pkg::ST_FREED;
      end else begin
        res.status = rce_pkg::ST_HELD;
      end
    end
    // evict free entries from the head while over the limit
    while (occ_cnt > max_ent && fl_head < CAP) begin
      s = fl_head;
      free_unlink(s);
      ent_valid[s] = 0;
      occ_cnt--;
      ev++;
    end
    res.evicted = ev[5:0];
    res.occupancy = occ_cnt[5:0];
    return res;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    if (out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
      $display("** refcounted_entry_cache: FAILED **");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("result with nothing expected at %0t", $realtime);
        errors++;
      end else begin
        lookup_res_t want;
        want = pending_results.pop_front();
        if (out_status !== want.status) report("status", 16'(out_status), 16'(want.status));
        if (out_slot !== want.slot) report("slot", 16'(out_slot), 16'(want.slot));
        if (out_ref_count !== want.refs) report("ref_count", out_ref_count, want.refs);
        if (out_evicted !== want.evicted)
          report("evicted", 16'(out_evicted), 16'(want.evicted));
        if (out_occupancy !== want.occupancy)
          report("occupancy", 16'(out_occupancy), 16'(want.occupancy));
      end
    end
  end

  // drive one request, hold until the transfer, then leave a gap
  task automatic send(logic act, logic [rce_pkg::KEY_W-1:0] key, int gap, bit typed = 0,
                      lookup_res_t typed_res = '{default: '0});
    lookup_res_t res;
    start <= 1;
    in_action <= act;
    in_address <= key[rce_pkg::KEY_W-1:rce_pkg::PORT_W];
    in_port <= key[rce_pkg::PORT_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    res = cache_step(act, key);
    pending_results.push_back(typed ? typed_res : res);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic settle_and_write(logic [rce_pkg::MAX_W-1:0] val);
    start <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    max_ent = int'(val);
  endtask

  table_row_t directed [10];
  logic [rce_pkg::MAX_W-1:0] limits [9] =
    '{6'd16, 6'd0, 6'd1, 6'd5, 6'd32, 6'd63, 6'd20, 6'd2, 6'd31};
  logic [rce_pkg::KEY_W-1:0] key_a = '0;
  logic [rce_pkg::KEY_W-1:0] key_b = '1;

  initial begin
    lookup_res_t tr;
    logic [rce_pkg::KEY_W-1:0] k;
    int get_pct;
    directed[0] = '{ACT_GET, '0, '0, 1, rce_pkg::ST_INSERTED, 5'd0, 16'd1, 6'd1};
    directed[1] = '{ACT_GET, '0, '0, 1, rce_pkg::ST_HIT, 5'd0, 16'd2, 6'd1};
    directed[2] = '{ACT_REL, '0, '0, 1, rce_pkg::ST_HELD, 5'd0, 16'd1, 6'd1};
    directed[3] = '{ACT_REL, '0, '0, 1, rce_pkg::ST_FREED, 5'd0, 16'd0, 6'd1};
    directed[4] = '{ACT_REL, '0, '0, 1, rce_pkg::ST_UNKNOWN, 5'd0, 16'd0, 6'd1};
    directed[5] = '{ACT_REL, '1, '1, 1, rce_pkg::ST_UNKNOWN, 5'd0, 16'd0, 6'd1};
    directed[6] = '{ACT_GET, '1, '1, 1, rce_pkg::ST_INSERTED, 5'd1, 16'd1, 6'd2};
    directed[7] = '{ACT_GET, '0, '0, 1, rce_pkg::ST_HIT, 5'd0, 16'd1, 6'd2};
    directed[8] = '{ACT_GET, 32'h8000_0001, 16'h8001, 0, '0, '0, '0, '0};
    directed[9] = '{ACT_REL, '1, '1, 0, '0, '0, '0, '0};
    key_pool[0] = key_a;
    key_pool[1] = key_b;
    for (int i = 2; i < 48; i++) key_pool[i] = {$urandom, 16'($urandom)};

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i]) begin
      tr.status = directed[i].status;
      tr.slot = directed[i].slot;
      tr.refs = directed[i].refs;
      tr.evicted = '0;
      tr.occupancy = directed[i].occ;
      send(directed[i].act, {directed[i].addr, directed[i].port}, i % 3,
           directed[i].typed, tr);
    end

    foreach (limits[p]) begin
      settle_and_write(limits[p]);
      // gets dominate on high limits so the table fills up
      get_pct = (limits[p] >= 32) ? 75 : 55;
      repeat (215) begin
        if ($urandom_range(99) < 8) k = {$urandom, 16'($urandom)};
        else k = key_pool[$urandom_range(47)];
        send(($urandom_range(99) < get_pct) ? ACT_GET : ACT_REL, k, pick_gap());
      end
    end

    start <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("** refcounted_entry_cache: PASSED **");
    else $display("** refcounted_entry_cache: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
